[rtl/phcf_pkg.sv]
// Package for the packet header classifier and filter.
// Holds the shared constants, the frame summary type and the filter settings type.
// No dependencies.
package phcf_pkg;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;

  localparam logic [7:0] IP_ICMP = 8'd1;
  localparam logic [7:0] IP_TCP  = 8'd6;
  localparam logic [7:0] IP_UDP  = 8'd17;

  localparam logic [15:0] PORT_HTTP = 16'd80;
  localparam logic [15:0] PORT_DNS  = 16'd53;

  localparam logic [2:0] CLS_UNKNOWN = 3'd0;
  localparam logic [2:0] CLS_TCP     = 3'd1;
  localparam logic [2:0] CLS_UDP     = 3'd2;
  localparam logic [2:0] CLS_ICMP    = 3'd3;
  localparam logic [2:0] CLS_ARP     = 3'd4;
  localparam logic [2:0] CLS_HTTP    = 3'd5;
  localparam logic [2:0] CLS_DNS     = 3'd6;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_HOST  = 2'd1;
  localparam logic [1:0] MODE_PORT  = 2'd2;
  localparam logic [1:0] MODE_CLASS = 2'd3;

  localparam logic [1:0] CFG_MODE    = 2'd0;
  localparam logic [1:0] CFG_ADDRESS = 2'd1;
  localparam logic [1:0] CFG_PORT    = 2'd2;
  localparam logic [1:0] CFG_CLASS   = 2'd3;

  // Frame byte offsets
  localparam logic [15:0] POS_TYPE_HI = 16'd12;
  localparam logic [15:0] POS_TYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL     = 16'd14;
  localparam logic [15:0] POS_TTL     = 16'd22;
  localparam logic [15:0] POS_PROTO   = 16'd23;
  localparam logic [15:0] POS_SRC_LO  = 16'd26;
  localparam logic [15:0] POS_SRC_HI  = 16'd29;
  localparam logic [15:0] POS_DST_LO  = 16'd30;
  localparam logic [15:0] POS_DST_HI  = 16'd33;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic        is_ip;
    logic        has_ports;
    logic [2:0]  cls;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [15:0] length;
  } hdr_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [15:0] port;
    logic [2:0]  cls;
  } filt_cfg_t;

endpackage

[rtl/phcf_front.sv]
// Front end: byte parser that captures header fields and classifies each frame.
// Emits one summary per IPv4 or ARP frame at its last byte. Uses phcf_pkg.
module phcf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              hdr_push,
  output phcf_pkg::hdr_t    hdr_data
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] type_r, type_nxt;
  logic [3:0]  hw_r, hw_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [31:0] ports_r, ports_nxt;
  logic [15:0] l4_base;
  logic        is_ip, is_arp, has_ports;
  logic [15:0] sp, dp;

  always_comb begin
    type_nxt  = type_r;
    hw_nxt    = hw_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ports_nxt = ports_r;
    if (pos_r == phcf_pkg::POS_TYPE_HI || pos_r == phcf_pkg::POS_TYPE_LO) begin
      type_nxt = {type_r[7:0], data_byte};
    end
    if (pos_r == phcf_pkg::POS_IHL) begin
      hw_nxt = data_byte[3:0];
    end
    if (pos_r == phcf_pkg::POS_TTL) begin
      ttl_nxt = data_byte;
    end
    if (pos_r == phcf_pkg::POS_PROTO) begin
      proto_nxt = data_byte;
    end
    if (pos_r >= phcf_pkg::POS_SRC_LO && pos_r <= phcf_pkg::POS_SRC_HI) begin
      src_nxt = {src_r[23:0], data_byte};
    end
    if (pos_r >= phcf_pkg::POS_DST_LO && pos_r <= phcf_pkg::POS_DST_HI) begin
      dst_nxt = {dst_r[23:0], data_byte};
    end
    // layer-4 offset follows the IHL just taken, even on the IHL byte itself
    l4_base = phcf_pkg::POS_IHL + {10'd0, hw_nxt, 2'b00};
    if (pos_r >= l4_base && pos_r < l4_base + 16'd4) begin
      ports_nxt = {ports_r[23:0], data_byte};
    end
    pos_nxt = (pos_r == phcf_pkg::POS_MAX) ? pos_r : pos_r + 16'd1;
  end

  // classify the frame from the captures including this beat
  always_comb begin
    is_ip     = (type_nxt == phcf_pkg::ETH_IPV4);
    is_arp    = (type_nxt == phcf_pkg::ETH_ARP);
    has_ports = is_ip && (proto_nxt == phcf_pkg::IP_TCP || proto_nxt == phcf_pkg::IP_UDP);
    sp        = has_ports ? ports_nxt[31:16] : 16'd0;
    dp        = has_ports ? ports_nxt[15:0] : 16'd0;

    hdr_data.is_ip     = is_ip;
    hdr_data.has_ports = has_ports;
    hdr_data.proto     = is_ip ? proto_nxt : 8'd0;
    hdr_data.ttl       = is_ip ? ttl_nxt : 8'd0;
    hdr_data.ip_src    = is_ip ? src_nxt : 32'd0;
    hdr_data.ip_dst    = is_ip ? dst_nxt : 32'd0;
    hdr_data.l4_sport  = sp;
    hdr_data.l4_dport  = dp;
    hdr_data.length    = pos_nxt;

    if (!is_ip) begin
      hdr_data.cls = phcf_pkg::CLS_ARP;
    end else if (proto_nxt == phcf_pkg::IP_ICMP) begin
      hdr_data.cls = phcf_pkg::CLS_ICMP;
    end else if (proto_nxt == phcf_pkg::IP_TCP) begin
      hdr_data.cls = (sp == phcf_pkg::PORT_HTTP || dp == phcf_pkg::PORT_HTTP) ?
                     phcf_pkg::CLS_HTTP : phcf_pkg::CLS_TCP;
    end else if (proto_nxt == phcf_pkg::IP_UDP) begin
      hdr_data.cls = (sp == phcf_pkg::PORT_DNS || dp == phcf_pkg::PORT_DNS) ?
                     phcf_pkg::CLS_DNS : phcf_pkg::CLS_UDP;
    end else begin
      hdr_data.cls = phcf_pkg::CLS_UNKNOWN;
    end

    // drop frames that are neither IPv4 nor ARP
    hdr_push = byte_vld && last_byte && (is_ip || is_arp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      type_r  <= '0;
      hw_r    <= '0;
      proto_r <= '0;
      ttl_r   <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      ports_r <= '0;
    end else if (byte_vld) begin
      if (last_byte) begin
        pos_r   <= '0;
        type_r  <= '0;
        hw_r    <= '0;
        proto_r <= '0;
        ttl_r   <= '0;
        src_r   <= '0;
        dst_r   <= '0;
        ports_r <= '0;
      end else begin
        pos_r   <= pos_nxt;
        type_r  <= type_nxt;
        hw_r    <= hw_nxt;
        proto_r <= proto_nxt;
        ttl_r   <= ttl_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
        ports_r <= ports_nxt;
      end
    end
  end

endmodule

[rtl/phcf_queue.sv]
// Short queue of frame summaries between the parser and the filter stage.
// Uses phcf_pkg for the summary type and depth.
module phcf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  phcf_pkg::hdr_t    push_data,
  output logic              full,
  input  logic              pop,
  output phcf_pkg::hdr_t    head,
  output logic              empty
);

  phcf_pkg::hdr_t                 entry_r [phcf_pkg::QDEPTH];
  logic [phcf_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [phcf_pkg::QPTR_W:0]      count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full    = (count_r == (phcf_pkg::QPTR_W + 1)'(phcf_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/phcf_back.sv]
// Back end: applies the filter to each summary, numbers accepted frames and
// holds the result register that the output side drains. Uses phcf_pkg.
module phcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  phcf_pkg::filt_cfg_t  cfg,
  input  logic                 q_empty,
  input  phcf_pkg::hdr_t       q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [31:0]          out_packet_number,
  output logic [2:0]           out_protocol_class,
  output logic [15:0]          out_ether_type,
  output logic [7:0]           out_ip_protocol,
  output logic [7:0]           out_time_to_live,
  output logic [31:0]          out_source_address,
  output logic [31:0]          out_dest_address,
  output logic [15:0]          out_source_port,
  output logic [15:0]          out_destination_port,
  output logic [15:0]          out_frame_length
);

  logic           out_vld_r;
  logic [31:0]    count_r;
  logic [31:0]    num_r;
  phcf_pkg::hdr_t res_r;
  logic           match, slot_free, load;

  always_comb begin
    unique case (cfg.mode)
      phcf_pkg::MODE_HOST: begin
        match = q_head.is_ip &&
                (q_head.ip_src == cfg.address || q_head.ip_dst == cfg.address);
      end
      phcf_pkg::MODE_PORT: begin
        match = q_head.has_ports &&
                (q_head.l4_sport == cfg.port || q_head.l4_dport == cfg.port);
      end
      phcf_pkg::MODE_CLASS: begin
        match = (q_head.cls == cfg.cls);
      end
      default: begin
        match = 1'b1;
      end
    endcase
  end

  // rejected beats drain at once; accepted ones wait for the result slot
  assign slot_free = !out_vld_r || out_pop;
  assign load      = !q_empty && match && slot_free;
  assign q_pop     = !q_empty && (!match || slot_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        count_r   <= count_r + 32'd1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= q_head;
      num_r <= count_r + 32'd1;
    end
  end

  assign out_empty            = !out_vld_r;
  assign out_packet_number    = num_r;
  assign out_protocol_class   = res_r.cls;
  assign out_ether_type       = res_r.is_ip ? phcf_pkg::ETH_IPV4 : phcf_pkg::ETH_ARP;
  assign out_ip_protocol      = res_r.proto;
  assign out_time_to_live     = res_r.ttl;
  assign out_source_address   = res_r.ip_src;
  assign out_dest_address     = res_r.ip_dst;
  assign out_source_port      = res_r.l4_sport;
  assign out_destination_port = res_r.l4_dport;
  assign out_frame_length     = res_r.length;

endmodule

[rtl/packet_header_classifier_filter.sv]
// Ethernet/IPv4/TCP-UDP header classifier and filter. Frame bytes enter one per
// cycle through push/full; each IPv4 or ARP frame that passes the filter leaves
// one result on the pop/empty side, written first to the summary queue and then
// to the result register once that is free. The parser takes one byte every
// cycle; a byte is held off only while the four-entry summary queue between
// parser and filter is full, which happens when results are not popped. The
// filter stage takes one summary per cycle unless a match waits for the result register.
module packet_header_classifier_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_packet_number,
  output logic [2:0]  out_protocol_class,
  output logic [15:0] out_ether_type,
  output logic [7:0]  out_ip_protocol,
  output logic [7:0]  out_time_to_live,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic [15:0] out_source_port,
  output logic [15:0] out_destination_port,
  output logic [15:0] out_frame_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  phcf_pkg::filt_cfg_t cfg_r;
  phcf_pkg::hdr_t      hdr_data, q_head;
  logic                hdr_push, q_full, q_empty, q_pop, byte_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phcf_pkg::CFG_MODE:    cfg_r.mode    <= cfg_data[1:0];
        phcf_pkg::CFG_ADDRESS: cfg_r.address <= cfg_data;
        phcf_pkg::CFG_PORT:    cfg_r.port    <= cfg_data[15:0];
        phcf_pkg::CFG_CLASS:   cfg_r.cls     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_full  = q_full;
  assign byte_vld = in_push && !q_full;

  phcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_vld),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .hdr_push  (hdr_push),
    .hdr_data  (hdr_data)
  );

  phcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (hdr_push),
    .push_data (hdr_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  phcf_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_packet_number    (out_packet_number),
    .out_protocol_class   (out_protocol_class),
    .out_ether_type       (out_ether_type),
    .out_ip_protocol      (out_ip_protocol),
    .out_time_to_live     (out_time_to_live),
    .out_source_address   (out_source_address),
    .out_dest_address     (out_dest_address),
    .out_source_port      (out_source_port),
    .out_destination_port (out_destination_port),
    .out_frame_length     (out_frame_length)
  );

endmodule

[tb/packet_header_classifier_filter_tb.sv]
// Self-checking testbench for packet_header_classifier_filter.
// Streams Ethernet frames byte by byte and predicts each frame report in a scoreboard class.
// Depends on phcf_pkg and the packet_header_classifier_filter RTL.
module packet_header_classifier_filter_tb;
  import phcf_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam logic [1:0]  MODE_ORDER [4] = '{MODE_NONE, MODE_HOST, MODE_PORT, MODE_CLASS};

  typedef struct packed {
    logic [31:0] packet_number;
    logic [2:0]  protocol_class;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [7:0]  time_to_live;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] frame_length;
  } frame_report_t;

  typedef struct {
    logic [15:0] ether_type;
    logic [7:0]  vihl;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    int unsigned len;
    bit          quiet;
  } frame_spec_t;

  class frame_scoreboard;
    filt_cfg_t     filters = '0;
    logic [15:0]   byte_pos = '0;
    logic [15:0]   type_cap = '0;
    logic [3:0]    hdr_words = '0;
    logic [7:0]    ttl_cap = '0;
    logic [7:0]    proto_cap = '0;
    logic [31:0]   src_cap = '0;
    logic [31:0]   dst_cap = '0;
    logic [31:0]   ports_cap = '0;
    logic [31:0]   frame_count = '0;
    frame_report_t reports_due[$];
    int unsigned   mismatches = 0;

    function void take_byte(logic [7:0] b, logic last);
      logic [15:0]   pos;
      logic [15:0]   port_base;
      logic          is_ip;
      logic          has_ports;
      logic          keep;
      frame_report_t r;
      pos = byte_pos;
      if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) type_cap = {type_cap[7:0], b};
      if (pos == POS_IHL) hdr_words = b[3:0];
      if (pos == POS_TTL) ttl_cap = b;
      if (pos == POS_PROTO) proto_cap = b;
      if (pos >= POS_SRC_LO && pos <= POS_SRC_HI) src_cap = {src_cap[23:0], b};
      if (pos >= POS_DST_LO && pos <= POS_DST_HI) dst_cap = {dst_cap[23:0], b};
      // Layer-4 window follows whatever IHL says, even below 5
      port_base = POS_IHL + {10'd0, hdr_words, 2'b00};
      if (pos >= port_base && pos < port_base + 16'd4) ports_cap = {ports_cap[23:0], b};
      if (!last) begin
        if (byte_pos != POS_MAX) byte_pos++;
        return;
      end
      if (type_cap == ETH_IPV4 || type_cap == ETH_ARP) begin
        is_ip = (type_cap == ETH_IPV4);
        has_ports = is_ip && (proto_cap == IP_TCP || proto_cap == IP_UDP);
        r.packet_number    = frame_count + 32'd1;
        r.ether_type       = is_ip ? ETH_IPV4 : ETH_ARP;
        r.ip_protocol      = is_ip ? proto_cap : '0;
        r.time_to_live     = is_ip ? ttl_cap : '0;
        r.source_address   = is_ip ? src_cap : '0;
        r.dest_address     = is_ip ? dst_cap : '0;
        r.source_port      = has_ports ? ports_cap[31:16] : '0;
        r.destination_port = has_ports ? ports_cap[15:0] : '0;
        r.frame_length     = (pos != POS_MAX) ? pos + 16'd1 : POS_MAX;
        if (!is_ip) r.protocol_class = CLS_ARP;
        else if (proto_cap == IP_ICMP) r.protocol_class = CLS_ICMP;
        else if (proto_cap == IP_TCP)
          r.protocol_class = (r.source_port == PORT_HTTP ||
                              r.destination_port == PORT_HTTP) ? CLS_HTTP : CLS_TCP;
        else if (proto_cap == IP_UDP)
          r.protocol_class = (r.source_port == PORT_DNS ||
                              r.destination_port == PORT_DNS) ? CLS_DNS : CLS_UDP;
        else r.protocol_class = CLS_UNKNOWN;
        case (filters.mode)
          MODE_HOST: keep = is_ip && (r.source_address == filters.address ||
                                      r.dest_address == filters.address);
          MODE_PORT: keep = has_ports && (r.source_port == filters.port ||
                                          r.destination_port == filters.port);
          MODE_CLASS: keep = (r.protocol_class == filters.cls);
          default: keep = 1'b1;
        endcase
        if (keep) begin
          frame_count++;
          reports_due.push_back(r);
        end
      end
      byte_pos = '0;
      type_cap = '0;
      hdr_words = '0;
      ttl_cap = '0;
      proto_cap = '0;
      src_cap = '0;
      dst_cap = '0;
      ports_cap = '0;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(frame_report_t got);
      frame_report_t want;
      if (reports_due.size() == 0) begin
        $error("report with no frame pending: packet_number 0x%0h", got.packet_number);
        mismatches++;
        return;
      end
      want = reports_due.pop_front();
      compare("packet_number", want.packet_number, got.packet_number);
      compare("protocol_class", 32'(want.protocol_class), 32'(got.protocol_class));
      compare("ether_type", 32'(want.ether_type), 32'(got.ether_type));
      compare("ip_protocol", 32'(want.ip_protocol), 32'(got.ip_protocol));
      compare("time_to_live", 32'(want.time_to_live), 32'(got.time_to_live));
      compare("source_address", want.source_address, got.source_address);
      compare("dest_address", want.dest_address, got.dest_address);
      compare("source_port", 32'(want.source_port), 32'(got.source_port));
      compare("destination_port", 32'(want.destination_port), 32'(got.destination_port));
      compare("frame_length", 32'(want.frame_length), 32'(got.frame_length));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_packet_number;
  logic [2:0]  out_protocol_class;
  logic [15:0] out_ether_type;
  logic [7:0]  out_ip_protocol;
  logic [7:0]  out_time_to_live;
  logic [31:0] out_source_address;
  logic [31:0] out_dest_address;
  logic [15:0] out_source_port;
  logic [15:0] out_destination_port;
  logic [15:0] out_frame_length;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  frame_scoreboard sb = new();
  bit              hold_rx = 1'b0;
  int unsigned     bytes_sent = 0;

  packet_header_classifier_filter u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_packet_number    (out_packet_number),
    .out_protocol_class   (out_protocol_class),
    .out_ether_type       (out_ether_type),
    .out_ip_protocol      (out_ip_protocol),
    .out_time_to_live     (out_time_to_live),
    .out_source_address   (out_source_address),
    .out_dest_address     (out_dest_address),
    .out_source_port      (out_source_port),
    .out_destination_port (out_destination_port),
    .out_frame_length     (out_frame_length),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] d, input logic last, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    do @(posedge clk); while (in_full !== 1'b0);
    sb.take_byte(d, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_spec_t f);
    logic [7:0]  hdr [80];
    int unsigned base;
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    {hdr[12], hdr[13]} = f.ether_type;
    hdr[14] = f.vihl;
    hdr[22] = f.ttl;
    hdr[23] = f.proto;
    {hdr[26], hdr[27], hdr[28], hdr[29]} = f.src;
    {hdr[30], hdr[31], hdr[32], hdr[33]} = f.dst;
    base = POS_IHL + 4 * f.vihl[3:0];
    // Below the address fields the ports overlap the IPv4 header; leave them as they fall
    if (base > POS_DST_HI)
      {hdr[base], hdr[base + 1], hdr[base + 2], hdr[base + 3]} = {f.sport, f.dport};
    for (int unsigned i = 0; i < f.len; i++)
      send_byte((i < 80) ? hdr[i] : 8'($urandom), i == f.len - 1,
                f.quiet ? 0 : $urandom_range(0, 9));
  endtask

  // Let queued reports come out and any dropped frame clear the pipeline
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input filt_cfg_t c);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data <= 32'(c.mode);
    @(negedge clk);
    cfg_index <= CFG_ADDRESS;
    cfg_data <= c.address;
    @(negedge clk);
    cfg_index <= CFG_PORT;
    cfg_data <= 32'(c.port);
    @(negedge clk);
    cfg_index <= CFG_CLASS;
    cfg_data <= 32'(c.cls);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.filters = c;
  endtask

  function automatic frame_spec_t ip_frame(logic [7:0] proto, logic [15:0] sport,
                                           logic [15:0] dport);
    frame_spec_t f;
    f.ether_type = ETH_IPV4;
    f.vihl = 8'h45;
    f.ttl = 8'($urandom);
    f.proto = proto;
    f.src = $urandom;
    f.dst = $urandom;
    f.sport = sport;
    f.dport = dport;
    f.len = 54 + $urandom_range(0, 12);
    f.quiet = ($urandom_range(0, 3) == 0);
    return f;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0: return PORT_HTTP;
      1: return PORT_DNS;
      2: return sb.filters.port;
      3: return 16'h0000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 4))
      0: return sb.filters.address;
      1: return 32'h0000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Half are TCP/UDP frames, then ICMP, odd protocols, ARP and junk ethertypes
  function automatic frame_spec_t random_frame();
    frame_spec_t f;
    int unsigned kind;
    int unsigned ihl;
    int unsigned full;
    kind = $urandom_range(0, 99);
    f = ip_frame(($urandom_range(0, 1) != 0) ? IP_TCP : IP_UDP, pick_port(), pick_port());
    if (kind >= 50 && kind < 60) f.proto = IP_ICMP;
    else if (kind >= 60 && kind < 68) f.proto = 8'($urandom);
    else if (kind >= 68 && kind < 80) f.ether_type = ETH_ARP;
    else if (kind >= 80 && kind < 90) f.ether_type = ETH_IPV4 ^ (16'd1 << $urandom_range(0, 15));
    else if (kind >= 90) f.ether_type = 16'($urandom);
    f.src = pick_address();
    f.dst = pick_address();
    if ($urandom_range(0, 6) == 0) f.vihl = 8'($urandom);
    ihl = f.vihl[3:0];
    full = POS_IHL + 4 * ((ihl < 5) ? 5 : ihl) + 4 + $urandom_range(0, 12);
    f.len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, full) : full;
    return f;
  endfunction

  initial begin : result_sink
    frame_report_t got;
    int unsigned   stall;
    int unsigned   pops;
    pops = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_rx) begin
        stall = HOLD_CYCLES;
        hold_rx = 1'b0;
      end else if (pops % 40 < 10) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 9);
      end
      repeat (stall) begin
        @(negedge clk);
        out_pop <= 1'b0;
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      got = {out_packet_number, out_protocol_class, out_ether_type, out_ip_protocol,
             out_time_to_live, out_source_address, out_dest_address, out_source_port,
             out_destination_port, out_frame_length};
      sb.check_report(got);
      pops++;
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    frame_spec_t f;
    filt_cfg_t   cfg;
    int unsigned phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg = '{mode: MODE_NONE, address: 32'h0A00_0001, port: PORT_HTTP, cls: CLS_TCP};
    configure(cfg);

    // Directed frames: every class, header extremes, odd IHL and short frames
    send_frame(ip_frame(IP_TCP, 16'd40000, PORT_HTTP));
    send_frame(ip_frame(IP_TCP, PORT_HTTP, 16'd443));
    send_frame(ip_frame(IP_TCP, 16'hFFFF, 16'h0000));
    send_frame(ip_frame(IP_UDP, 16'd5353, PORT_DNS));
    send_frame(ip_frame(IP_UDP, 16'd4000, 16'd5000));
    send_frame(ip_frame(IP_ICMP, 16'd0, 16'd0));
    f = ip_frame(8'hFF, 16'd0, 16'd0);
    f.ttl = 8'hFF;
    f.src = 32'hFFFF_FFFF;
    f.dst = 32'hFFFF_FFFF;
    f.vihl = 8'hFF;
    send_frame(f);
    f = ip_frame(8'h00, 16'd0, 16'd0);
    f.ttl = 8'h00;
    f.src = 32'h0;
    f.dst = 32'h0;
    f.vihl = 8'h00;
    send_frame(f);
    f = ip_frame(IP_TCP, PORT_HTTP, PORT_HTTP);
    f.vihl = 8'h40;
    send_frame(f);
    f = ip_frame(IP_UDP, 16'd1, 16'd2);
    f.vihl = 8'h44;
    send_frame(f);
    f = ip_frame(IP_TCP, 16'd1, 16'd2);
    f.vihl = 8'h4F;
    f.len = 80;
    send_frame(f);
    f = ip_frame(IP_TCP, 16'd1234, 16'd5678);
    f.len = 36;
    send_frame(f);
    f.len = 20;
    send_frame(f);
    f.ether_type = ETH_ARP;
    f.len = 42;
    send_frame(f);
    f.len = 14;
    send_frame(f);
    f.ether_type = 16'hFFFF;
    send_frame(f);
    f.ether_type = 16'h0000;
    send_frame(f);
    f.len = 1;
    send_frame(f);
    f.ether_type = ETH_IPV4;
    f.len = 13;
    send_frame(f);

    phase = 0;
    while (phase < 8 || bytes_sent < 1450) begin
      drain();
      cfg.mode = MODE_ORDER[phase % 4];
      case ((phase / 4) % 4)
        0: cfg = '{mode: cfg.mode, address: 32'h0, port: 16'h0, cls: 3'h7};
        1: cfg = '{mode: cfg.mode, address: 32'hFFFF_FFFF, port: 16'hFFFF, cls: CLS_UNKNOWN};
        2: cfg = '{mode: cfg.mode, address: $urandom, port: PORT_HTTP, cls: CLS_DNS};
        default: cfg = '{mode: cfg.mode, address: $urandom, port: 16'($urandom),
                         cls: 3'($urandom)};
      endcase
      configure(cfg);
      if (phase == 0) begin
        // Hold the result side while short frames keep coming, to back up the block
        hold_rx = 1'b1;
        repeat (10) begin
          f = ip_frame(IP_TCP, pick_port(), pick_port());
          f.quiet = 1'b1;
          f.len = 38;
          if ($urandom_range(0, 1) != 0) begin
            f.ether_type = ETH_ARP;
            f.len = 14;
          end
          send_frame(f);
        end
      end else begin
        repeat ($urandom_range(1, 2)) send_frame(random_frame());
      end
      phase++;
    end
    drain();

    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[packet_header_classifier_filter.f]
rtl/phcf_pkg.sv
rtl/phcf_front.sv
rtl/phcf_queue.sv
rtl/phcf_back.sv
rtl/packet_header_classifier_filter.sv
tb/packet_header_classifier_filter_tb.sv
